// ===== rtl/tscg_pkg.sv =====
package tscg_pkg;

  typedef logic signed [63:0] dword_t;
  typedef logic signed [31:0] coef_t;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } arith_op_t;

  // one operation for the shared arithmetic unit
  typedef struct packed {
    logic      start;
    arith_op_t op;
    logic      rnd;
    dword_t    a;
    dword_t    b;
  } arith_req_t;

  // coefficient store write from the sequencer
  typedef struct packed {
    logic       en;
    logic [3:0] idx;
    coef_t      data;
  } store_wr_t;

  localparam int NUM_COEF = 10;
  localparam logic [6:0] MUL_STEPS = 7'd48;
  localparam logic [6:0] DIV_STEPS = 7'd65;

endpackage

// ===== rtl/tscg_arith.sv =====
module tscg_arith (
  input  logic                clk,
  input  logic                rst_n,
  input  tscg_pkg::arith_req_t req,
  output logic                done,
  output tscg_pkg::dword_t    res
);
  import tscg_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [6:0]  cnt_r;
  arith_op_t   op_r;
  logic        rnd_r;
  logic        neg_r;
  logic [95:0] acc_r;
  logic [95:0] mcand_r;
  logic [47:0] mplier_r;
  logic [64:0] num_r;
  logic [63:0] den_r;
  logic [65:0] rem_r;
  logic [64:0] quo_r;
  dword_t      res_r;

  logic [63:0] a_mag;
  logic [63:0] b_mag;
  logic [63:0] den_mag;
  logic [65:0] rem_shift;
  logic        rem_ge;
  logic [95:0] rnd_sum;
  logic [63:0] fin_mag;
  logic [6:0]  last_cnt;

  always_comb begin
    a_mag     = req.a[63] ? 64'(-req.a) : 64'(req.a);
    b_mag     = req.b[63] ? 64'(-req.b) : 64'(req.b);
    den_mag   = (b_mag == 64'd0) ? 64'd1 : b_mag;
    rem_shift = {rem_r[64:0], num_r[64]};
    rem_ge    = rem_shift >= {2'b00, den_r};
    rnd_sum   = acc_r + (96'd1 << 29);
    if (op_r == OP_MUL) begin
      fin_mag  = rnd_r ? rnd_sum[93:30] : acc_r[63:0];
      last_cnt = MUL_STEPS;
    end else begin
      fin_mag  = quo_r[63:0];
      last_cnt = DIV_STEPS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == last_cnt) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r     <= req.op;
      rnd_r    <= req.rnd;
      neg_r    <= req.a[63] ^ req.b[63];
      acc_r    <= '0;
      mcand_r  <= {48'd0, a_mag[47:0]};
      mplier_r <= b_mag[47:0];
      num_r    <= 65'(a_mag) + 65'(den_mag >> 1);
      den_r    <= den_mag;
      rem_r    <= '0;
      quo_r    <= '0;
    end else if (busy_r && cnt_r != last_cnt) begin
      if (op_r == OP_MUL) begin
        acc_r    <= acc_r + (mplier_r[0] ? mcand_r : 96'd0);
        mcand_r  <= mcand_r << 1;
        mplier_r <= mplier_r >> 1;
      end else begin
        rem_r <= rem_ge ? (rem_shift - {2'b00, den_r}) : rem_shift;
        quo_r <= {quo_r[63:0], rem_ge};
        num_r <= num_r << 1;
      end
    end else if (busy_r) begin
      res_r <= neg_r ? -dword_t'(fin_mag) : dword_t'(fin_mag);
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// ===== rtl/tscg_seq.sv =====
module tscg_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [16:0]        tone,
  input  logic               boost,
  input  logic [17:0]        fs,
  output logic               done,
  output tscg_pkg::store_wr_t wr
);
  import tscg_pkg::*;

  localparam dword_t Q30_ONE     = 64'sd1073741824;
  localparam dword_t LN10_Q30    = 64'sd2472381918;
  localparam dword_t TWO_PI_Q30  = 64'sd6746518852;
  localparam dword_t PI_Q30      = 64'sd3373259426;
  localparam dword_t HALF_PI_Q30 = 64'sd1686629713;
  localparam dword_t DB_DIV_A    = 64'sd2621440;
  localparam dword_t DB_DIV_SA   = 64'sd5242880;
  localparam dword_t LOW_FC      = 64'sd200;
  localparam dword_t HIGH_FC     = 64'sd3000;
  localparam dword_t ALPHA_NUM   = 64'sd1000;
  localparam dword_t ALPHA_DEN   = 64'sd1414;
  localparam dword_t TONE_HALF   = 64'sd32768;
  localparam dword_t COEF_MAX    = 64'sd2147483647;
  localparam dword_t COEF_MIN    = -64'sd2147483648;

  typedef enum logic [2:0] {
    SQ_IDLE  = 3'b001,
    SQ_ISSUE = 3'b010,
    SQ_WAIT  = 3'b100
  } sq_state_t;

  typedef enum logic [21:0] {
    ST_LNMUL = 22'h000001,
    ST_YA    = 22'h000002,
    ST_YS    = 22'h000004,
    ST_EM    = 22'h000008,
    ST_ED    = 22'h000010,
    ST_WMUL  = 22'h000020,
    ST_WDIV  = 22'h000040,
    ST_X2    = 22'h000080,
    ST_SM    = 22'h000100,
    ST_SD    = 22'h000200,
    ST_CM    = 22'h000400,
    ST_CD    = 22'h000800,
    ST_SN    = 22'h001000,
    ST_AL1   = 22'h002000,
    ST_AL2   = 22'h004000,
    ST_KK    = 22'h008000,
    ST_T1    = 22'h010000,
    ST_T2    = 22'h020000,
    ST_B0    = 22'h040000,
    ST_B1    = 22'h080000,
    ST_B2    = 22'h100000,
    ST_NRM   = 22'h200000
  } step_t;

  function automatic dword_t sin_div(input logic [3:0] k);
    int n;
    n = int'(k);
    return dword_t'((2 * n) * (2 * n + 1));
  endfunction

  function automatic dword_t cos_div(input logic [3:0] k);
    int n;
    n = int'(k);
    return dword_t'((2 * n - 1) * (2 * n));
  endfunction

  sq_state_t  sq_state_r;
  step_t      step_r;
  logic       done_r;
  logic [3:0] cnt_r;
  logic       shelf_r;
  logic       esel_r;
  logic       flip_r;
  logic [16:0] tone_r;
  logic       boost_r;
  logic [17:0] fs_r;
  dword_t t_r, ya_r, ys_r, m_r, r_r, amp_r, samp_r, th_r, x2_r, s_r, c_r;
  dword_t sn_r, alpha_r, kprod_r, t1_r, t2_r, n0_r, n1_r, n2_r;

  arith_req_t ar_req;
  logic       ar_done;
  dword_t     ar_res;

  dword_t tone_dist, db_lo, db_hi, db;
  dword_t ap1, am1, tt, vv, ww, a0, a0c, a1, a2, num;
  dword_t r_next;
  coef_t  sat_res;

  tscg_arith u_arith (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (ar_req),
    .done (ar_done),
    .res  (ar_res)
  );

  // shelf gains in 2^-16 dB
  always_comb begin
    if (dword_t'({47'd0, tone_r}) <= TONE_HALF) begin
      tone_dist = TONE_HALF - dword_t'({47'd0, tone_r});
      db_lo     = tone_dist * 2;
      db_hi     = -(tone_dist * 5);
    end else begin
      tone_dist = dword_t'({47'd0, tone_r}) - TONE_HALF;
      db_lo     = -tone_dist;
      db_hi     = tone_dist * 5;
    end
    if (boost_r) begin
      db_lo = db_lo * 3;
      db_hi = db_hi * 3;
    end
    db = shelf_r ? db_hi : db_lo;
  end

  always_comb begin
    ap1 = amp_r + Q30_ONE;
    am1 = amp_r - Q30_ONE;
    tt  = shelf_r ? t1_r : -t1_r;
    vv  = shelf_r ? (am1 + t2_r) : (am1 - t2_r);
    ww  = shelf_r ? (am1 - t2_r) : (am1 + t2_r);
    a0  = ap1 - tt + kprod_r;
    a2  = ap1 - tt - kprod_r;
    a1  = shelf_r ? (ww * 2) : -(ww * 2);
    a0c = (a0 < 64'sd1) ? 64'sd1 : a0;
    case (cnt_r)
      4'd0:    num = n0_r;
      4'd1:    num = n1_r;
      4'd2:    num = n2_r;
      4'd3:    num = a1;
      default: num = a2;
    endcase
    r_next = Q30_ONE + ar_res;
    if (ar_res > COEF_MAX) begin
      sat_res = coef_t'(COEF_MAX);
    end else if (ar_res < COEF_MIN) begin
      sat_res = coef_t'(COEF_MIN);
    end else begin
      sat_res = ar_res[31:0];
    end
  end

  always_comb begin
    ar_req.start = sq_state_r == SQ_ISSUE;
    ar_req.op    = OP_MUL;
    ar_req.rnd   = 1'b1;
    ar_req.a     = '0;
    ar_req.b     = '0;
    case (step_r)
      ST_LNMUL: begin
        ar_req.rnd = 1'b0;
        ar_req.a   = db;
        ar_req.b   = LN10_Q30;
      end
      ST_YA: begin
        ar_req.op = OP_DIV;
        ar_req.a  = t_r;
        ar_req.b  = DB_DIV_A;
      end
      ST_YS: begin
        ar_req.op = OP_DIV;
        ar_req.a  = t_r;
        ar_req.b  = DB_DIV_SA;
      end
      ST_EM: begin
        ar_req.a = esel_r ? ys_r : ya_r;
        ar_req.b = r_r;
      end
      ST_ED: begin
        ar_req.op = OP_DIV;
        ar_req.a  = m_r;
        ar_req.b  = dword_t'({60'd0, cnt_r});
      end
      ST_WMUL: begin
        ar_req.rnd = 1'b0;
        ar_req.a   = shelf_r ? HIGH_FC : LOW_FC;
        ar_req.b   = TWO_PI_Q30;
      end
      ST_WDIV: begin
        ar_req.op = OP_DIV;
        ar_req.a  = t_r;
        ar_req.b  = dword_t'({46'd0, fs_r});
      end
      ST_X2: begin
        ar_req.a = th_r;
        ar_req.b = th_r;
      end
      ST_SM: begin
        ar_req.a = x2_r;
        ar_req.b = s_r;
      end
      ST_SD: begin
        ar_req.op = OP_DIV;
        ar_req.a  = m_r;
        ar_req.b  = sin_div(cnt_r);
      end
      ST_CM: begin
        ar_req.a = x2_r;
        ar_req.b = c_r;
      end
      ST_CD: begin
        ar_req.op = OP_DIV;
        ar_req.a  = m_r;
        ar_req.b  = cos_div(cnt_r);
      end
      ST_SN: begin
        ar_req.a = th_r;
        ar_req.b = s_r;
      end
      ST_AL1: begin
        ar_req.rnd = 1'b0;
        ar_req.a   = sn_r;
        ar_req.b   = ALPHA_NUM;
      end
      ST_AL2: begin
        ar_req.op = OP_DIV;
        ar_req.a  = t_r;
        ar_req.b  = ALPHA_DEN;
      end
      ST_KK: begin
        ar_req.a = samp_r;
        ar_req.b = alpha_r;
      end
      ST_T1: begin
        ar_req.a = am1;
        ar_req.b = c_r;
      end
      ST_T2: begin
        ar_req.a = ap1;
        ar_req.b = c_r;
      end
      ST_B0: begin
        ar_req.a = amp_r;
        ar_req.b = ap1 + tt + kprod_r;
      end
      ST_B1: begin
        ar_req.a = amp_r;
        ar_req.b = vv;
      end
      ST_B2: begin
        ar_req.a = amp_r;
        ar_req.b = ap1 + tt - kprod_r;
      end
      ST_NRM: begin
        ar_req.op = OP_DIV;
        ar_req.a  = num <<< 28;
        ar_req.b  = a0c;
      end
      default: begin
        ar_req.a = '0;
      end
    endcase
  end

  always_comb begin
    wr.en   = (sq_state_r == SQ_WAIT) && ar_done && (step_r == ST_NRM);
    wr.idx  = shelf_r ? (4'd5 + cnt_r) : cnt_r;
    wr.data = sat_res;
  end

  // control: state, step, loop counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_state_r <= SQ_IDLE;
      step_r     <= ST_LNMUL;
      done_r     <= 1'b0;
      cnt_r      <= '0;
      shelf_r    <= 1'b0;
      esel_r     <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (sq_state_r)
        SQ_IDLE: begin
          if (start) begin
            sq_state_r <= SQ_ISSUE;
            step_r     <= ST_LNMUL;
            shelf_r    <= 1'b0;
          end
        end
        SQ_ISSUE: begin
          sq_state_r <= SQ_WAIT;
        end
        SQ_WAIT: begin
          if (ar_done) begin
            sq_state_r <= SQ_ISSUE;
            case (step_r)
              ST_LNMUL: step_r <= ST_YA;
              ST_YA:    step_r <= ST_YS;
              ST_YS: begin
                step_r <= ST_EM;
                cnt_r  <= 4'd12;
                esel_r <= 1'b0;
              end
              ST_EM: step_r <= ST_ED;
              ST_ED: begin
                if (cnt_r == 4'd1) begin
                  if (!esel_r) begin
                    esel_r <= 1'b1;
                    cnt_r  <= 4'd12;
                    step_r <= ST_EM;
                  end else begin
                    step_r <= ST_WMUL;
                  end
                end else begin
                  cnt_r  <= cnt_r - 4'd1;
                  step_r <= ST_EM;
                end
              end
              ST_WMUL: step_r <= ST_WDIV;
              ST_WDIV: step_r <= ST_X2;
              ST_X2: begin
                step_r <= ST_SM;
                cnt_r  <= 4'd10;
              end
              ST_SM: step_r <= ST_SD;
              ST_SD: step_r <= ST_CM;
              ST_CM: step_r <= ST_CD;
              ST_CD: begin
                if (cnt_r == 4'd1) begin
                  step_r <= ST_SN;
                end else begin
                  cnt_r  <= cnt_r - 4'd1;
                  step_r <= ST_SM;
                end
              end
              ST_SN:  step_r <= ST_AL1;
              ST_AL1: step_r <= ST_AL2;
              ST_AL2: step_r <= ST_KK;
              ST_KK:  step_r <= ST_T1;
              ST_T1:  step_r <= ST_T2;
              ST_T2:  step_r <= ST_B0;
              ST_B0:  step_r <= ST_B1;
              ST_B1:  step_r <= ST_B2;
              ST_B2: begin
                step_r <= ST_NRM;
                cnt_r  <= 4'd0;
              end
              ST_NRM: begin
                if (cnt_r == 4'd4) begin
                  if (!shelf_r) begin
                    shelf_r <= 1'b1;
                    step_r  <= ST_LNMUL;
                  end else begin
                    sq_state_r <= SQ_IDLE;
                    done_r     <= 1'b1;
                  end
                end else begin
                  cnt_r <= cnt_r + 4'd1;
                end
              end
              default: step_r <= ST_LNMUL;
            endcase
          end
        end
        default: sq_state_r <= SQ_IDLE;
      endcase
    end
  end

  // working registers, written back from the arithmetic unit
  always_ff @(posedge clk) begin
    if (sq_state_r == SQ_IDLE && start) begin
      tone_r  <= tone;
      boost_r <= boost;
      fs_r    <= fs;
    end
    if (sq_state_r == SQ_WAIT && ar_done) begin
      case (step_r)
        ST_LNMUL: t_r <= ar_res;
        ST_YA:    ya_r <= ar_res;
        ST_YS: begin
          ys_r <= ar_res;
          r_r  <= Q30_ONE;
        end
        ST_EM: m_r <= ar_res;
        ST_ED: begin
          if (cnt_r == 4'd1) begin
            r_r <= Q30_ONE;
            if (!esel_r) begin
              amp_r <= r_next;
            end else begin
              samp_r <= r_next;
            end
          end else begin
            r_r <= r_next;
          end
        end
        ST_WMUL: t_r <= ar_res;
        ST_WDIV: begin
          // fold angles above a quarter turn
          if (ar_res > HALF_PI_Q30) begin
            th_r   <= PI_Q30 - ar_res;
            flip_r <= 1'b1;
          end else begin
            th_r   <= ar_res;
            flip_r <= 1'b0;
          end
        end
        ST_X2: begin
          x2_r <= ar_res;
          s_r  <= Q30_ONE;
          c_r  <= Q30_ONE;
        end
        ST_SM: m_r <= ar_res;
        ST_SD: s_r <= Q30_ONE - ar_res;
        ST_CM: m_r <= ar_res;
        ST_CD: c_r <= Q30_ONE - ar_res;
        ST_SN: begin
          sn_r <= ar_res;
          if (flip_r) begin
            c_r <= -c_r;
          end
        end
        ST_AL1: t_r <= ar_res;
        ST_AL2: alpha_r <= ar_res;
        ST_KK:  kprod_r <= ar_res * 2;
        ST_T1:  t1_r <= ar_res;
        ST_T2:  t2_r <= ar_res;
        ST_B0:  n0_r <= ar_res;
        ST_B1:  n1_r <= shelf_r ? -(ar_res * 2) : (ar_res * 2);
        ST_B2:  n2_r <= ar_res;
        default: begin
          m_r <= m_r;
        end
      endcase
    end
  end

  assign done = done_r;

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    ar_done |-> sq_state_r == SQ_WAIT)
    else $error("arithmetic result outside wait state");

  a_last_write_before_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(wr.en) && $past(wr.idx) == 4'd9)
    else $error("sequence finished without writing last coefficient");

endmodule

// ===== rtl/tone_shelf_coefficient_gen_unit.sv =====
// Tone shelf coefficient generator.
// Input channel (in_valid / in_stall): one transaction carries a tone level
// (unsigned Q1.16) and a boost flag. Output channel (out_valid / out_stall):
// one transaction per input carries ten signed Q3.28 biquad coefficients,
// low shelf at 200 Hz and high shelf at 3000 Hz, plus a recomputed flag.
// cfg_wr_en / cfg_sample_rate_hz set the sample rate; write it only while
// the block is idle.
// A transaction whose tone, boost and rate match the last computed set goes
// straight to the load state and is presented on the output once the output
// register is free; the next one is accepted once the block is idle again.
// Otherwise a sequencer drives one shared multiply / divide unit through
// 108 operations per shelf.
// in_stall stays high from acceptance until the result is moved into the
// output register, so one transaction is in flight at a time.
// While out_stall is high the output register holds; the next input may
// already be accepted and its result waits until the output register frees.
// Reset sets the rate to 48000 Hz and invalidates the cache, so the first
// transaction always recomputes.
module tone_shelf_coefficient_gen_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [16:0]         in_tone_level,
  input  logic                in_tone_boost,
  output logic                out_valid,
  input  logic                out_stall,
  output tscg_pkg::coef_t     out_low_b0,
  output tscg_pkg::coef_t     out_low_b1,
  output tscg_pkg::coef_t     out_low_b2,
  output tscg_pkg::coef_t     out_low_a1,
  output tscg_pkg::coef_t     out_low_a2,
  output tscg_pkg::coef_t     out_high_b0,
  output tscg_pkg::coef_t     out_high_b1,
  output tscg_pkg::coef_t     out_high_b2,
  output tscg_pkg::coef_t     out_high_a1,
  output tscg_pkg::coef_t     out_high_a2,
  output logic                out_recomputed,
  input  logic                cfg_wr_en,
  input  logic [17:0]         cfg_sample_rate_hz
);
  import tscg_pkg::*;

  localparam logic [16:0] TONE_MAX  = 17'd65536;
  localparam logic [17:0] RATE_RST  = 18'd48000;
  localparam logic [17:0] RATE_MIN  = 18'd8000;
  localparam logic [17:0] RATE_MAX  = 18'd192000;

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_CALC = 3'b010,
    T_LOAD = 3'b100
  } top_state_t;

  top_state_t  state_r;
  logic [17:0] rate_r;
  logic [16:0] cached_tone_r;
  logic        cached_boost_r;
  logic [17:0] cached_rate_r;
  logic        cache_valid_r;
  logic        recomp_r;
  logic        out_valid_r;
  logic        out_rec_r;
  coef_t       store_r [NUM_COEF];
  coef_t       out_coef_r [NUM_COEF];

  logic [16:0] tone_sat;
  logic [17:0] fs_clamp;
  logic        accept;
  logic        redo;
  logic        out_free;
  logic        seq_done;
  store_wr_t   seq_wr;

  always_comb begin
    tone_sat = (in_tone_level > TONE_MAX) ? TONE_MAX : in_tone_level;
    if (rate_r < RATE_MIN) begin
      fs_clamp = RATE_MIN;
    end else if (rate_r > RATE_MAX) begin
      fs_clamp = RATE_MAX;
    end else begin
      fs_clamp = rate_r;
    end
    accept   = in_valid && (state_r == T_IDLE);
    redo     = !cache_valid_r || (tone_sat != cached_tone_r) ||
               (in_tone_boost != cached_boost_r) || (rate_r != cached_rate_r);
    out_free = !out_valid_r || !out_stall;
  end

  assign in_stall = state_r != T_IDLE;

  tscg_seq u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .start(accept && redo),
    .tone (tone_sat),
    .boost(in_tone_boost),
    .fs   (fs_clamp),
    .done (seq_done),
    .wr   (seq_wr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= T_IDLE;
      rate_r         <= RATE_RST;
      cached_tone_r  <= '0;
      cached_boost_r <= 1'b0;
      cached_rate_r  <= '0;
      cache_valid_r  <= 1'b0;
      recomp_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        rate_r <= cfg_sample_rate_hz;
      end
      // drop the output unless a load refills it this cycle
      if (out_valid_r && !out_stall && state_r != T_LOAD) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        T_IDLE: begin
          if (accept) begin
            recomp_r <= redo;
            if (redo) begin
              cached_tone_r  <= tone_sat;
              cached_boost_r <= in_tone_boost;
              cached_rate_r  <= rate_r;
              cache_valid_r  <= 1'b1;
              state_r        <= T_CALC;
            end else begin
              state_r <= T_LOAD;
            end
          end
        end
        T_CALC: begin
          if (seq_done) begin
            state_r <= T_LOAD;
          end
        end
        T_LOAD: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (seq_wr.en) begin
      store_r[seq_wr.idx] <= seq_wr.data;
    end
    if (state_r == T_LOAD && out_free) begin
      out_coef_r <= store_r;
      out_rec_r  <= recomp_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_recomputed = out_rec_r;
  assign out_low_b0     = out_coef_r[0];
  assign out_low_b1     = out_coef_r[1];
  assign out_low_b2     = out_coef_r[2];
  assign out_low_a1     = out_coef_r[3];
  assign out_low_a2     = out_coef_r[4];
  assign out_high_b0    = out_coef_r[5];
  assign out_high_b1    = out_coef_r[6];
  assign out_high_b2    = out_coef_r[7];
  assign out_high_a1    = out_coef_r[8];
  assign out_high_a2    = out_coef_r[9];

  a_seq_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    seq_done |-> state_r == T_CALC)
    else $error("sequencer finished outside a recompute");

  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == T_LOAD))
    else $error("output raised without a load");

endmodule
